// ===== hdl/jse_pkg.sv =====
// Shared types and constants for the JTAG shift engine.
package jse_pkg;

  localparam int MAX_BITS_DEF = 64;
  localparam int PORT_BITS    = 64;
  localparam int CNT_W        = 7;
  localparam int ACK_W        = 3;
  localparam int RETRY_W      = 16;
  localparam int APB_AW       = 3;
  localparam int APB_DW       = 32;

  localparam logic [ACK_W-1:0] ACK_OK   = 3'd1;
  localparam logic [ACK_W-1:0] ACK_WAIT = 3'd2;

  // ack field sits above this TDO bit
  localparam logic [CNT_W-1:0] ACK_BASE = 7'd32;

  // register index decoded from paddr
  localparam logic REG_RESHIFT_MAX = 1'b0;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [CNT_W-1:0]     len;
    logic [PORT_BITS-1:0] tms;
    logic [PORT_BITS-1:0] tdi;
    logic [4:0]           ack_pos;
    logic                 tdo;
  } cmd_t;

  typedef struct packed {
    logic                 tms_out;
    logic                 tdi_out;
    logic                 tck_pulse;
    logic [PORT_BITS-1:0] tdo_bits;
    logic [ACK_W-1:0]     ack_status;
    logic                 done_res;
    logic                 accepted;
    logic                 busy_res;
  } res_t;

endpackage

// ===== hdl/jse_front.sv =====
// Front end: decodes incoming beats and holds them in a two-entry command queue.
module jse_front import jse_pkg::*; #(
  parameter int MAX_BITS = MAX_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           operation,
  input  logic [CNT_W-1:0]     bit_count,
  input  logic [PORT_BITS-1:0] tms_bits,
  input  logic [PORT_BITS-1:0] tdi_bits,
  input  logic [4:0]           ack_position,
  input  logic                 tdo_sample,
  output logic                 cmd_valid,
  output cmd_t                 cmd,
  input  logic                 cmd_pop
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  cmd_t       cmd_in;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    cmd_in.op      = op_t'(operation);
    cmd_in.tms     = tms_bits;
    cmd_in.tdi     = tdi_bits;
    cmd_in.ack_pos = ack_position;
    cmd_in.tdo     = tdo_sample;
    // zero length means one bit, oversize clamps to the shifter width
    if (bit_count == '0) begin
      cmd_in.len = CNT_W'(1);
    end else if (bit_count > CNT_W'(MAX_BITS)) begin
      cmd_in.len = CNT_W'(MAX_BITS);
    end else begin
      cmd_in.len = bit_count;
    end
  end

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("command queue overflow");

endmodule

// ===== hdl/jse_exec.sv =====
// Back end: shift state machine, acknowledge check and WAIT retry.
module jse_exec import jse_pkg::*; #(
  parameter int MAX_BITS = MAX_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [RETRY_W-1:0] reshift_max,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_pop,
  input  logic               res_full,
  output logic               res_push,
  output res_t               res
);

  localparam int IW = $clog2(MAX_BITS);
  localparam int CW = $clog2(MAX_BITS + 1);

  logic                active, active_next;
  logic [CW-1:0]       bit_index, bit_index_next;
  logic [CW-1:0]       length, length_next;
  logic [MAX_BITS-1:0] tms_store, tms_store_next;
  logic [MAX_BITS-1:0] tdi_store, tdi_store_next;
  logic [MAX_BITS-1:0] tdo_store, tdo_store_next;
  logic [4:0]          ack_offset, ack_offset_next;
  logic [RETRY_W-1:0]  retries_used, retries_used_next;
  logic [ACK_W-1:0]    sticky_ack, sticky_ack_next;

  logic                go;
  logic [IW-1:0]       idx;
  logic [CW-1:0]       bit_inc;
  logic [MAX_BITS-1:0] tdo_upd;
  logic [ACK_W-1:0]    ack_raw;
  logic [ACK_W-1:0]    ack;

  assign go       = cmd_valid && !res_full;
  assign cmd_pop  = go;
  assign res_push = go;
  assign idx      = bit_index[IW-1:0];
  assign bit_inc  = bit_index + CW'(1);

  always_comb begin
    tdo_upd      = tdo_store;
    tdo_upd[idx] = cmd.tdo;
  end

  // three ack bits above bit 32; bits past the shifter read as zero
  always_comb begin
    logic [CNT_W-1:0] k;
    for (int j = 0; j < ACK_W; j++) begin
      k = ACK_BASE + CNT_W'(ack_offset) + CNT_W'(j);
      ack_raw[j] = (k < CNT_W'(MAX_BITS)) ? tdo_upd[k[IW-1:0]] : 1'b0;
    end
    ack = (ack_offset != '0) ? {ack_raw[2], ack_raw[0], ack_raw[1]} : ACK_OK;
  end

  always_comb begin
    active_next       = active;
    bit_index_next    = bit_index;
    length_next       = length;
    tms_store_next    = tms_store;
    tdi_store_next    = tdi_store;
    tdo_store_next    = tdo_store;
    ack_offset_next   = ack_offset;
    retries_used_next = retries_used;
    sticky_ack_next   = sticky_ack;
    res               = '0;

    case (cmd.op)
      OP_START: begin
        if (!active && sticky_ack == ACK_OK) begin
          length_next       = cmd.len[CW-1:0];
          tms_store_next    = cmd.tms[MAX_BITS-1:0];
          tdi_store_next    = cmd.tdi[MAX_BITS-1:0];
          ack_offset_next   = cmd.ack_pos;
          tdo_store_next    = '0;
          bit_index_next    = '0;
          retries_used_next = '0;
          active_next       = 1'b1;
          res.accepted      = 1'b1;
        end
      end
      OP_TICK: begin
        if (active) begin
          res.tms_out    = tms_store[idx];
          res.tdi_out    = tdi_store[idx];
          res.tck_pulse  = 1'b1;
          tdo_store_next = tdo_upd;
          bit_index_next = bit_inc;
          if (bit_inc >= length) begin
            if (ack_offset != '0 && ack == ACK_WAIT && retries_used < reshift_max) begin
              retries_used_next = retries_used + RETRY_W'(1);
              bit_index_next    = '0;
            end else begin
              sticky_ack_next = ack;
              active_next     = 1'b0;
              res.done_res    = 1'b1;
              res.tdo_bits    = PORT_BITS'(tdo_upd);
            end
          end
        end
      end
      OP_CLEAR: begin
        sticky_ack_next = ACK_OK;
      end
      default: begin
      end
    endcase

    res.ack_status = sticky_ack_next;
    res.busy_res   = active_next;
  end

  always_ff @(posedge clk) begin
    if (go) begin
      tms_store  <= tms_store_next;
      tdi_store  <= tdi_store_next;
      tdo_store  <= tdo_store_next;
      ack_offset <= ack_offset_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      bit_index    <= '0;
      length       <= '0;
      retries_used <= '0;
      sticky_ack   <= ACK_OK;
    end else if (go) begin
      active       <= active_next;
      bit_index    <= bit_index_next;
      length       <= length_next;
      retries_used <= retries_used_next;
      sticky_ack   <= sticky_ack_next;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    active |-> (bit_index < length))
    else $error("bit index past transfer length");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.done_res) |=> !active)
    else $error("engine still active after done");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.accepted) |-> (res.busy_res && !active))
    else $error("start accepted while busy");

  a_retry_bound: assert property (@(posedge clk) disable iff (rst)
    (go && cmd.op == OP_TICK && retries_used_next != retries_used)
      |-> (retries_used < reshift_max))
    else $error("retry taken past limit");

endmodule

// ===== hdl/jse_rfifo.sv =====
// Result queue: two-entry buffer between the engine and the pop side.
module jse_rfifo import jse_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic res_push,
  input  res_t res_in,
  output logic res_full,
  output logic empty,
  input  logic pop,
  output res_t res_out
);

  res_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_pop;

  assign res_full = (cnt == 2'd2);
  assign empty    = (cnt == 2'd0);
  assign res_out  = q[rd_ptr];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

endmodule

// ===== hdl/jtag_shift_engine_with_ack_retry.sv =====
// JTAG shift engine top level: APB register, command queue, engine, result queue.
//
// Usage: push beats into the input queue (push/full). Each beat is a start,
// a TCK tick, a sticky-ack clear or a no-op, and yields exactly one result
// beat on the output queue (empty/pop), in order. A start loads up to
// MAX_BITS TMS and TDI bits; each following tick shifts one bit, LSB first,
// and captures TDO. On the last bit an optional 3-bit ack is checked; WAIT
// restarts the shift up to reshift_max times, set through APB at byte
// address 0. Throughput: one beat per clock unless the result queue fills;
// the engine updates its shift registers once per beat. A beat accepted
// into the command queue passes through the engine into the result queue
// and then appears on the result ports. If pop stays low the result queue
// fills, the engine stops taking commands and full rises once two commands
// wait; nothing is lost. Reset (synchronous rst) empties both queues, ends
// any transfer, sets the sticky ack to OK and reshift_max to zero.
module jtag_shift_engine_with_ack_retry import jse_pkg::*; #(
  parameter int MAX_BITS = MAX_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           operation,
  input  logic [CNT_W-1:0]     bit_count,
  input  logic [PORT_BITS-1:0] tms_bits,
  input  logic [PORT_BITS-1:0] tdi_bits,
  input  logic [4:0]           ack_position,
  input  logic                 tdo_sample,
  output logic                 empty,
  input  logic                 pop,
  output logic                 tms_out,
  output logic                 tdi_out,
  output logic                 tck_pulse,
  output logic [PORT_BITS-1:0] tdo_bits,
  output logic [ACK_W-1:0]     ack_status,
  output logic                 done_res,
  output logic                 accepted,
  output logic                 busy_res,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  logic               cmd_valid;
  cmd_t               cmd;
  logic               cmd_pop;
  logic               res_push;
  logic               res_full;
  res_t               res;
  res_t               res_out;
  logic [RETRY_W-1:0] reshift_max;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_RESHIFT_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      reshift_max <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      reshift_max <= pwdata[RETRY_W-1:0];
    end
  end

  assign prdata = reg_sel ? APB_DW'(reshift_max) : '0;

  jse_front #(.MAX_BITS(MAX_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .operation    (operation),
    .bit_count    (bit_count),
    .tms_bits     (tms_bits),
    .tdi_bits     (tdi_bits),
    .ack_position (ack_position),
    .tdo_sample   (tdo_sample),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  jse_exec #(.MAX_BITS(MAX_BITS)) u_exec (
    .clk         (clk),
    .rst         (rst),
    .reshift_max (reshift_max),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res         (res)
  );

  jse_rfifo u_rfifo (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_in   (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .res_out  (res_out)
  );

  assign tms_out    = res_out.tms_out;
  assign tdi_out    = res_out.tdi_out;
  assign tck_pulse  = res_out.tck_pulse;
  assign tdo_bits   = res_out.tdo_bits;
  assign ack_status = res_out.ack_status;
  assign done_res   = res_out.done_res;
  assign accepted   = res_out.accepted;
  assign busy_res   = res_out.busy_res;

endmodule
